[sv/vom_pkg.sv]
// ----------------------------------------------------------------------------
// vom_pkg
// Shared constants, codes and types of the voxel occupancy match scorer.
// ----------------------------------------------------------------------------
package vom_pkg;

  // Map geometry
  localparam int GRID_CELLS = 1048576;
  localparam int MAX_POINTS = 65535;
  localparam int WORD_BITS  = 64;
  localparam int WORD_SEL   = $clog2(WORD_BITS);
  localparam int MAP_WORDS  = (GRID_CELLS + WORD_BITS - 1) / WORD_BITS;
  localparam int MAP_AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IDX_W      = $clog2(GRID_CELLS);

  // Shifted index: cell + offset_x + offset_y * row_stride, signed
  localparam int SUM_W  = (IDX_W + 2 > 23) ? IDX_W + 2 : 23;
  localparam int PROD_W = 22;

  // Point count saturation limit
  localparam int PT_CAP = (MAX_POINTS < 65535) ? MAX_POINTS : 65535;

  // Field widths
  localparam int CELL_W   = 20;
  localparam int OFS_W    = 10;
  localparam int CNT_W    = 16;
  localparam int STRIDE_W = 11;
  localparam int FUNC_W   = 2;
  localparam int IN_W     = 56;
  localparam int OUT_W    = 104;

  // Function codes
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FN_MARK  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SCORE = 2'd2;

  // Map controller states
  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_CALC,
    ST_ADDR,
    ST_LOOK
  } map_state_t;

  // One scored point (or a clear request) from map controller to scorer
  typedef struct packed {
    logic             vld;
    logic             clr;
    logic             hit;
    logic             last;
    logic [CNT_W-1:0] cand;
  } pt_t;

endpackage

[sv/vom_ram.sv]
// ----------------------------------------------------------------------------
// vom_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vom_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/vom_map.sv]
// ----------------------------------------------------------------------------
// vom_map
// Map controller: input transfer, index arithmetic, occupancy memory access
// (read for score, read-modify-write for mark) and the clearing sweep.
// ----------------------------------------------------------------------------
module vom_map import vom_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_W-1:0]     s_tdata,
  input  logic [FUNC_W-1:0]   s_tuser,
  input  logic                s_tlast,
  input  logic                cfg_we,
  input  logic [STRIDE_W-1:0] cfg_wdata,
  input  logic                score_busy,
  output pt_t                 pt
);

  map_state_t state, state_next;

  logic [STRIDE_W-1:0] row_stride;
  logic [FUNC_W-1:0]   fn;
  logic [CELL_W-1:0]   cell_idx;
  logic [OFS_W-1:0]    ox;
  logic [OFS_W-1:0]    oy;
  logic [CNT_W-1:0]    cand;
  logic                last;
  logic [PROD_W-1:0]   prod;
  logic [WORD_SEL-1:0] bitsel;
  logic                inrng;
  logic [MAP_AW-1:0]   clr_cnt;

  logic                accept;
  logic [SUM_W-1:0]    idx;
  logic                idx_ok;
  logic                ram_we;
  logic [MAP_AW-1:0]   ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                ram_re;
  logic [MAP_AW-1:0]   ram_raddr;
  logic [MAP_AW-1:0]   look_addr;
  logic [WORD_BITS-1:0] ram_rdata;

  assign accept = s_tvalid && s_tready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_stride <= STRIDE_W'(1);
    end else if (cfg_we) begin
      row_stride <= cfg_wdata;
    end
  end

  // Shifted index, plain cell index for mark
  always_comb begin
    if (fn == FN_SCORE) begin
      idx = SUM_W'(cell_idx) + SUM_W'($signed(ox)) + SUM_W'($signed(prod));
    end else begin
      idx = SUM_W'(cell_idx);
    end
    idx_ok = !idx[SUM_W-1] && (idx < SUM_W'(GRID_CELLS));
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLR: begin
        if (clr_cnt == MAP_AW'(MAP_WORDS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (s_tuser)
            FN_CLEAR: state_next = ST_CLR;
            FN_MARK:  state_next = ST_CALC;
            FN_SCORE: state_next = ST_CALC;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_CALC: state_next = ST_ADDR;
      ST_ADDR: state_next = ST_LOOK;
      ST_LOOK: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and memory controls
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = look_addr;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = idx[MAP_AW+WORD_SEL-1:WORD_SEL];
    pt        = '0;
    pt.cand   = cand;
    pt.last   = last;
    case (state)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        pt.clr    = 1'b1;
      end
      ST_IDLE: begin
        s_tready = !score_busy;
      end
      ST_ADDR: begin
        ram_re = idx_ok;
      end
      ST_LOOK: begin
        if (fn == FN_MARK) begin
          ram_we    = inrng;
          ram_wdata = ram_rdata | (WORD_BITS'(1) << bitsel);
        end else begin
          pt.vld = 1'b1;
          pt.hit = inrng && ram_rdata[bitsel];
        end
      end
      default: ;
    endcase
  end

  // State and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLR) begin
        clr_cnt <= clr_cnt + MAP_AW'(1);
      end else begin
        clr_cnt <= '0;
      end
    end
  end

  // Item capture and address pipeline
  always_ff @(posedge clk) begin
    if (accept) begin
      fn       <= s_tuser;
      cell_idx <= s_tdata[19:0];
      ox       <= s_tdata[29:20];
      oy       <= s_tdata[39:30];
      cand     <= s_tdata[55:40];
      last     <= s_tlast;
    end
    if (state == ST_CALC) begin
      prod <= PROD_W'($signed(oy)) * PROD_W'($signed({1'b0, row_stride}));
    end
    if (state == ST_ADDR) begin
      bitsel    <= idx[WORD_SEL-1:0];
      inrng     <= idx_ok;
      look_addr <= idx[MAP_AW+WORD_SEL-1:WORD_SEL];
    end
  end

  // Occupancy map, one bit per cell, packed into words
  vom_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[sv/vom_score.sv]
// ----------------------------------------------------------------------------
// vom_score
// Hit and point accumulation, best-ratio tracking and the result register.
// ----------------------------------------------------------------------------
module vom_score import vom_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  pt_t              pt,
  output logic             busy,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata
);

  logic [CNT_W-1:0]   hit_acc;
  logic [CNT_W-1:0]   point_acc;
  logic [CNT_W-1:0]   best_id;
  logic [CNT_W-1:0]   best_hit_reg;
  logic [CNT_W-1:0]   best_point_reg;
  logic               best_valid;
  logic               fin;
  logic               cmp;
  logic [CNT_W-1:0]   cand_q;
  logic [2*CNT_W-1:0] prod_new;
  logic [2*CNT_W-1:0] prod_best;
  logic               better;
  logic               fire;

  assign busy   = fin || cmp;
  assign better = !best_valid || (prod_new > prod_best);
  assign fire   = cmp && (!m_tvalid || m_tready);

  // Control: accumulators, best record, stage flags, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_acc        <= '0;
      point_acc      <= '0;
      best_id        <= '0;
      best_hit_reg   <= '0;
      best_point_reg <= '0;
      best_valid     <= 1'b0;
      fin            <= 1'b0;
      cmp            <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      // clear request
      if (pt.clr) begin
        hit_acc        <= '0;
        point_acc      <= '0;
        best_id        <= '0;
        best_hit_reg   <= '0;
        best_point_reg <= '0;
        best_valid     <= 1'b0;
      end
      // count a point unless saturated
      if (pt.vld) begin
        if (point_acc < CNT_W'(PT_CAP)) begin
          point_acc <= point_acc + CNT_W'(1);
          hit_acc   <= hit_acc + CNT_W'(pt.hit);
        end
        fin <= pt.last;
      end
      // cross products ready
      if (fin) begin
        fin <= 1'b0;
        cmp <= 1'b1;
      end
      // decide and load result
      if (fire) begin
        cmp       <= 1'b0;
        m_tvalid  <= 1'b1;
        hit_acc   <= '0;
        point_acc <= '0;
        if (better) begin
          best_valid     <= 1'b1;
          best_id        <= cand_q;
          best_hit_reg   <= hit_acc;
          best_point_reg <= point_acc;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pt.vld && pt.last) begin
      cand_q <= pt.cand;
    end
    if (fin) begin
      prod_new  <= (2*CNT_W)'(hit_acc) * (2*CNT_W)'(best_point_reg);
      prod_best <= (2*CNT_W)'(best_hit_reg) * (2*CNT_W)'(point_acc);
    end
    if (fire) begin
      m_tdata[15:0]   <= cand_q;
      m_tdata[31:16]  <= hit_acc;
      m_tdata[47:32]  <= point_acc;
      m_tdata[63:48]  <= better ? cand_q : best_id;
      m_tdata[79:64]  <= better ? hit_acc : best_hit_reg;
      m_tdata[95:80]  <= better ? point_acc : best_point_reg;
      m_tdata[96]     <= better;
      m_tdata[103:97] <= '0;
    end
  end

endmodule

[sv/voxel_occupancy_match_scorer_core.sv]
// ----------------------------------------------------------------------------
// voxel_occupancy_match_scorer_core
// Scores candidate poses against a one-bit voxel occupancy map.
// ----------------------------------------------------------------------------
// Input stream (s_*): tuser selects the function (clear, mark, score), tlast
// marks the final point of a candidate. Output stream (m_*): one result per
// candidate, sent after its last point. The configuration write port sets
// the row stride at any time; change it only while the block is idle.
//
// For mark and score items the map controller computes the shifted index
// (multiply, then add), reads the occupancy word from the registered-read
// memory and, for mark, writes it back; no input is taken meanwhile. The last
// point of a candidate adds the cross-product and compare steps before
// the next input transfer; the compare step loads the result register.
// A clear item sweeps the map one 64-bit word a cycle (MAP_WORDS words,
// 16384 at the default map size). After reset the same sweep runs with
// s_tready low. A result held by a stalled receiver does not block further
// input until the next candidate ends; that result then waits for it, and
// input stalls with it.
// ----------------------------------------------------------------------------
module voxel_occupancy_match_scorer_core import vom_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // cell_index[19:0], offset_x[29:20], offset_y[39:30], candidate_id[55:40]
  input  logic [IN_W-1:0]     s_tdata,
  // func[1:0]
  input  logic [FUNC_W-1:0]   s_tuser,
  // last_point
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  // cand_out[15:0], hit_count[31:16], point_count[47:32], best_cand[63:48],
  // best_hits[79:64], best_points[95:80], new_best[96], zero[103:97]
  output logic [OUT_W-1:0]    m_tdata,
  input  logic                cfg_we,
  input  logic [STRIDE_W-1:0] cfg_wdata
);

  pt_t  pt;
  logic score_busy;

  // Index arithmetic and occupancy memory
  vom_map u_map (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .score_busy (score_busy),
    .pt         (pt)
  );

  // Accumulation, best tracking, result register
  vom_score u_score (
    .clk      (clk),
    .rst      (rst),
    .pt       (pt),
    .busy     (score_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[sim/vom_score_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vom_score_checker
// Watches the scorer's streams, predicts each candidate result and compares.
// ----------------------------------------------------------------------------
// Clear, mark and score transfers update a private occupancy map, the counts
// and the best-candidate record. A score transfer with tlast queues the
// expected result. Every output transfer is compared field by field against
// the oldest queued result. Mismatches and unexpected results bump
// fail_count; pending tells the stimulus side how many results are due.
// ----------------------------------------------------------------------------
module vom_score_checker import vom_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  // cell_index, offset_x, offset_y, candidate_id
  input  logic [IN_W-1:0]     s_tdata,
  // func
  input  logic [FUNC_W-1:0]   s_tuser,
  // last_point
  input  logic                s_tlast,
  input  logic                m_tvalid,
  input  logic                m_tready,
  // cand_out, hit_count, point_count, best_cand, best_hits, best_points,
  // new_best, zero pad
  input  logic [OUT_W-1:0]    m_tdata,
  input  logic                cfg_we,
  input  logic [STRIDE_W-1:0] cfg_wdata,
  output int                  fail_count,
  output int                  pending
);

  // Bit positions inside s_tdata
  localparam int OX_LO   = CELL_W;
  localparam int OY_LO   = CELL_W + OFS_W;
  localparam int CAND_LO = CELL_W + 2 * OFS_W;

  typedef struct {
    logic [CNT_W-1:0] cand;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] points;
    logic [CNT_W-1:0] best_cand;
    logic [CNT_W-1:0] best_hits;
    logic [CNT_W-1:0] best_points;
    logic             new_best;
  } score_rec_t;

  score_rec_t          due_scores[$];
  bit                  occ_map[int];
  logic [CNT_W-1:0]    hit_run;
  logic [CNT_W-1:0]    point_run;
  logic [CNT_W-1:0]    best_id;
  logic [CNT_W-1:0]    best_hit_cnt;
  logic [CNT_W-1:0]    best_point_cnt;
  logic                best_seen;
  logic [STRIDE_W-1:0] stride;

  // Clear: empty map, drop counts and the best record
  function automatic void wipe_map();
    occ_map.delete();
    hit_run        = '0;
    point_run      = '0;
    best_id        = '0;
    best_hit_cnt   = '0;
    best_point_cnt = '0;
    best_seen      = 1'b0;
  endfunction

  // One scored point; on the last point, rank the candidate and queue it
  function automatic void score_point(input logic [CELL_W-1:0] cell_idx,
                                      input logic signed [OFS_W-1:0] ox,
                                      input logic signed [OFS_W-1:0] oy,
                                      input logic [CNT_W-1:0] cand,
                                      input logic last);
    longint          idx;
    longint unsigned lhs;
    longint unsigned rhs;
    logic            better;
    score_rec_t      rec;
    // saturated candidates ignore further points entirely
    if (point_run < PT_CAP) begin
      idx = longint'(cell_idx) + longint'(ox) + longint'(oy) * longint'(stride);
      point_run++;
      if (idx >= 0 && idx < GRID_CELLS && occ_map.exists(int'(idx)))
        hit_run++;
    end
    if (last) begin
      lhs    = 64'(hit_run) * 64'(best_point_cnt);
      rhs    = 64'(best_hit_cnt) * 64'(point_run);
      better = !best_seen || (lhs > rhs);
      if (better) begin
        best_seen      = 1'b1;
        best_id        = cand;
        best_hit_cnt   = hit_run;
        best_point_cnt = point_run;
      end
      rec.cand        = cand;
      rec.hits        = hit_run;
      rec.points      = point_run;
      rec.best_cand   = best_id;
      rec.best_hits   = best_hit_cnt;
      rec.best_points = best_point_cnt;
      rec.new_best    = better;
      due_scores.insert(due_scores.size(), rec);
      hit_run   = '0;
      point_run = '0;
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result(input logic [OUT_W-1:0] beat);
    score_rec_t want;
    if (due_scores.size() == 0) begin
      $error("result transfer with no candidate due: cand_out %0d", beat[15:0]);
      fail_count++;
    end else begin
      want = due_scores.pop_front();
      check_field("cand_out",    int'(want.cand),        int'(beat[15:0]));
      check_field("hit_count",   int'(want.hits),        int'(beat[31:16]));
      check_field("point_count", int'(want.points),      int'(beat[47:32]));
      check_field("best_cand",   int'(want.best_cand),   int'(beat[63:48]));
      check_field("best_hits",   int'(want.best_hits),   int'(beat[79:64]));
      check_field("best_points", int'(want.best_points), int'(beat[95:80]));
      check_field("new_best",    int'(want.new_best),    int'(beat[96]));
      check_field("pad",         0,                      int'(beat[OUT_W-1:97]));
    end
  endfunction

  // Sample all channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      wipe_map();
      stride = STRIDE_W'(1);
      due_scores.delete();
    end else begin
      if (cfg_we)
        stride = cfg_wdata;
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          FN_CLEAR: wipe_map();
          FN_MARK:  occ_map[int'(s_tdata[CELL_W-1:0])] = 1'b1;
          FN_SCORE: score_point(s_tdata[CELL_W-1:0],
                                s_tdata[OX_LO +: OFS_W],
                                s_tdata[OY_LO +: OFS_W],
                                s_tdata[CAND_LO +: CNT_W],
                                s_tlast);
          default: ;
        endcase
      end
      if (m_tvalid && m_tready)
        check_result(m_tdata);
    end
    pending = due_scores.size();
  end

endmodule

[sim/tb_voxel_occupancy_match_scorer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_occupancy_match_scorer_core
// Stimulus and verdict for the voxel occupancy match scorer.
// ----------------------------------------------------------------------------
// A directed run covers the field extremes, out-of-map scored indices, the
// first candidate, a ratio tie, clear and the unused function code. Random
// phases then build map regions with marks and score candidates against
// them under several row strides (zero and the maximum among them), mixed
// with noise points, interrupted candidates and stray clears. Both stream
// sides idle at random; the checker module predicts and compares every
// result.
// ----------------------------------------------------------------------------
module tb_voxel_occupancy_match_scorer_core;
  import vom_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 260;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata   = '0;
  logic [FUNC_W-1:0]   s_tuser   = '0;
  logic                s_tlast   = 1'b0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [OUT_W-1:0]    m_tdata;
  logic                cfg_we    = 1'b0;
  logic [STRIDE_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int items_sent   = 0;
  int spare_clears = 2;
  bit calm         = 1'b0;

  always #5 clk = ~clk;

  voxel_occupancy_match_scorer_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  vom_score_checker score_chk (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Run limit
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random stall before each transfer
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // One input transfer; called and returns at a falling edge, tvalid left high
  task automatic push_item(input logic [FUNC_W-1:0] fn, input logic [CELL_W-1:0] cell_idx,
                           input logic signed [OFS_W-1:0] ox,
                           input logic signed [OFS_W-1:0] oy,
                           input logic [CNT_W-1:0] cand, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tlast  <= last;
    s_tdata  <= {cand, oy, ox, cell_idx};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (fn != FN_UNUSED)
      items_sent++;
  endtask

  // Hold input until every due result has come
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Row stride update, only with the block idle
  task automatic write_stride(input logic [STRIDE_W-1:0] value);
    drain_results();
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One candidate: usually a fixed offset over points in the map region;
  // noisy ones use random cells, offsets and ids per point
  task automatic run_candidate(input int base, input int span, input bit noisy);
    int                      npts;
    logic [CNT_W-1:0]        cand;
    logic signed [OFS_W-1:0] ox;
    logic signed [OFS_W-1:0] oy;
    logic [CELL_W-1:0]       cell_idx;
    npts = $urandom_range(1, 12);
    cand = CNT_W'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        ox = '0;
        oy = '0;
      end
      1, 2: begin
        ox = OFS_W'($urandom_range(0, 6) - 3);
        oy = OFS_W'($urandom_range(0, 2) - 1);
      end
      default: begin
        ox = OFS_W'($urandom);
        oy = OFS_W'($urandom);
      end
    endcase
    for (int k = 0; k < npts; k++) begin
      cell_idx = CELL_W'(base + $urandom_range(0, span - 1));
      if (noisy) begin
        cell_idx = CELL_W'($urandom);
        ox       = OFS_W'($urandom);
        oy       = OFS_W'($urandom);
        if ($urandom_range(0, 1) == 0)
          cell_idx = CELL_W'(base + $urandom_range(0, span - 1));
        if (k != npts - 1)
          cand = CNT_W'($urandom);
        // broken sequence: mark or clear inside a candidate
        if ($urandom_range(0, 4) == 0)
          push_item(FN_MARK, CELL_W'(base + $urandom_range(0, span - 1)), '0, '0, '0, 1'b0);
        if (spare_clears > 0 && $urandom_range(0, 19) == 0) begin
          spare_clears--;
          push_item(FN_CLEAR, CELL_W'($urandom), OFS_W'($urandom), OFS_W'($urandom),
                    CNT_W'($urandom), 1'($urandom));
        end
      end
      push_item(FN_SCORE, cell_idx, ox, oy, cand, k == npts - 1);
    end
  endtask

  // Marks, candidates and noise around one map region
  task automatic random_phase(input int n_items);
    int base;
    int span;
    int start;
    int pick;
    base = $urandom_range(0, GRID_CELLS - 1);
    case ($urandom_range(0, 2))
      0:       span = 64;
      1:       span = 512;
      default: span = 4096;
    endcase
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)
        push_item(FN_MARK, CELL_W'(base + $urandom_range(0, span - 1)),
                  OFS_W'($urandom), OFS_W'($urandom), CNT_W'($urandom), 1'($urandom));
      else if (pick < 33)
        push_item(FN_UNUSED, CELL_W'($urandom), OFS_W'($urandom), OFS_W'($urandom),
                  CNT_W'($urandom), 1'($urandom));
      else if (pick < 34)
        drain_results();
      else
        run_candidate(base, span, pick >= 90);
    end
    // close on a finished candidate so the block is idle after the drain
    run_candidate(base, span, 1'b0);
  endtask

  // Stimulus
  initial begin
    logic [STRIDE_W-1:0] strides[6];
    strides[0] = STRIDE_W'(1);
    strides[1] = STRIDE_W'(0);
    strides[2] = STRIDE_W'(2047);
    strides[3] = STRIDE_W'(64);
    strides[4] = STRIDE_W'($urandom_range(1, 1024));
    strides[5] = STRIDE_W'($urandom_range(0, 2047));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: map corners, a row step, and offset extremes
    write_stride(STRIDE_W'(1024));
    push_item(FN_MARK, 20'd0, '0, '0, '0, 1'b0);
    push_item(FN_MARK, 20'hFFFFF, '0, '0, '0, 1'b0);
    push_item(FN_MARK, 20'd5000, '0, '0, '0, 1'b0);
    push_item(FN_MARK, 20'd3079, '0, '0, '0, 1'b0);
    // unused code with every bit set does nothing
    push_item(FN_UNUSED, 20'hFFFFF, -10'sd1, -10'sd1, 16'hFFFF, 1'b1);
    // first candidate becomes best even with no hits
    push_item(FN_SCORE, 20'd6000, '0, '0, 16'hFFFF, 1'b1);
    // hits at both corners, negative and past-the-end indices miss
    push_item(FN_SCORE, 20'd0, '0, '0, 16'd1, 1'b0);
    push_item(FN_SCORE, 20'hFFFFF, '0, '0, 16'd1, 1'b0);
    push_item(FN_SCORE, 20'd0, -10'sd1, '0, 16'd1, 1'b0);
    push_item(FN_SCORE, 20'hFFFFF, 10'sd511, '0, 16'd1, 1'b1);
    // y step by row stride, x extremes
    push_item(FN_SCORE, 20'd7, '0, 10'sd3, 16'd2, 1'b0);
    push_item(FN_SCORE, 20'd5512, -10'sd512, '0, 16'd2, 1'b0);
    push_item(FN_SCORE, 20'd4489, 10'sd511, '0, 16'd2, 1'b0);
    push_item(FN_SCORE, 20'd6000, '0, '0, 16'd2, 1'b1);
    push_item(FN_SCORE, 20'd0, '0, '0, 16'd3, 1'b0);
    push_item(FN_SCORE, 20'd3079, '0, '0, 16'd3, 1'b1);
    // equal ratio keeps the earlier best
    push_item(FN_SCORE, 20'd5000, '0, '0, 16'd4, 1'b0);
    push_item(FN_SCORE, 20'd0, '0, '0, 16'd4, 1'b1);
    push_item(FN_SCORE, 20'hFFFFF, -10'sd512, -10'sd512, 16'd0, 1'b0);
    push_item(FN_SCORE, 20'd0, 10'sd511, 10'sd511, 16'd0, 1'b1);
    // clear resets the map and the best record
    push_item(FN_CLEAR, '0, '0, '0, '0, 1'b0);
    push_item(FN_SCORE, 20'd0, '0, '0, 16'd5, 1'b1);

    // Random phases under several strides
    for (int p = 0; p < 6; p++) begin
      write_stride(strides[p]);
      calm = (p == 3);
      if (p % 2 == 0)
        push_item(FN_CLEAR, CELL_W'($urandom), OFS_W'($urandom), OFS_W'($urandom),
                  CNT_W'($urandom), 1'($urandom));
      random_phase(PHASE_ITEMS);
    end
    calm = 1'b0;

    drain_results();
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
